// ===== design/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg: shared widths and types for the box gap distance block
// Fixed result widths and the per-cell payload of the square root chain.
// ----------------------------------------------------------------------------
package aabb_pkg;

    // Result distance width, unsigned Q13.4
    localparam int DIST_BITS = 17;
    // One clamped axis gap squared
    localparam int SQ_BITS   = 2 * DIST_BITS;
    // Sum of three squares
    localparam int SUM_BITS  = SQ_BITS + 2;
    // Root of the sum: one bit per cell
    localparam int ROOT_BITS = SUM_BITS / 2;
    // Partial remainder inside the chain
    localparam int REM_BITS  = ROOT_BITS + 2;

    typedef struct packed {
        logic [SUM_BITS-1:0]  rad;    // radicand bits not yet consumed, top first
        logic [REM_BITS-1:0]  rem;    // running remainder
        logic [ROOT_BITS-1:0] root;   // root bits found so far
        logic                 big;    // some axis gap beyond the result range
        logic                 touch;  // all axis gaps zero
    } t_sqrt_data;

endpackage

// ===== design/aabb_box_if.sv =====
// ----------------------------------------------------------------------------
// aabb_box_if: box pair channel
// Valid/ready channel carrying the min and max corners of two boxes.
// ----------------------------------------------------------------------------
interface aabb_box_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_min_x;
    logic signed [COORD_BITS-1:0] a_min_y;
    logic signed [COORD_BITS-1:0] a_min_z;
    logic signed [COORD_BITS-1:0] a_max_x;
    logic signed [COORD_BITS-1:0] a_max_y;
    logic signed [COORD_BITS-1:0] a_max_z;
    logic signed [COORD_BITS-1:0] b_min_x;
    logic signed [COORD_BITS-1:0] b_min_y;
    logic signed [COORD_BITS-1:0] b_min_z;
    logic signed [COORD_BITS-1:0] b_max_x;
    logic signed [COORD_BITS-1:0] b_max_y;
    logic signed [COORD_BITS-1:0] b_max_z;

    modport source (
        output valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
               b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z,
        input  ready
    );
    modport sink (
        input  valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
               b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z,
        output ready
    );
endinterface

// ===== design/aabb_dist_if.sv =====
// ----------------------------------------------------------------------------
// aabb_dist_if: distance result channel
// Valid/ready channel carrying the gap distance and the touching flag.
// ----------------------------------------------------------------------------
interface aabb_dist_if;
    logic                           valid;
    logic                           ready;
    logic [aabb_pkg::DIST_BITS-1:0] gap_distance;
    logic                           touching;

    modport source (
        output valid, gap_distance, touching,
        input  ready
    );
    modport sink (
        input  valid, gap_distance, touching,
        output ready
    );
endinterface

// ===== design/aabb_gap_distance_3d.sv =====
// ----------------------------------------------------------------------------
// aabb_gap_distance_3d: Euclidean gap between two axis-aligned boxes
// Front end of gaps and squares, a chain of square root cells, output skid.
// ----------------------------------------------------------------------------
// Usage:
//   i_box carries one box pair per transfer (min and max corners, signed
//   Q11.4 at the default width). o_dist returns one transfer per pair, in
//   order: gap_distance (unsigned Q13.4, floor of the Euclidean gap,
//   saturated at the top of its range) and touching (all axis gaps zero,
//   distance then reads 0).
//   Pipeline: three register stages in the gap/square/sum front end, then
//   one per root bit in an 18-cell chain, all ahead of o_dist.valid.
//   Throughput: one pair per cycle while the skid is empty; all stages share one enable.
//   When the receiver stalls, the result at the end of the chain drops into
//   a one-entry skid register and the whole pipeline holds until the skid
//   empties; i_box.ready is the registered skid-empty flag, so no new pair
//   is taken while a finished result still waits.
//   Reset (synchronous, active low) clears every stage valid and the skid;
//   in-flight pairs are dropped, payload registers keep whatever they held.
// ----------------------------------------------------------------------------
module aabb_gap_distance_3d #(
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aabb_box_if.sink    i_box,
    aabb_dist_if.source o_dist
);
    localparam int QB = aabb_pkg::ROOT_BITS;
    localparam int DB = aabb_pkg::DIST_BITS;

    logic signed [COORD_BITS-1:0] w_a_min [3];
    logic signed [COORD_BITS-1:0] w_a_max [3];
    logic signed [COORD_BITS-1:0] w_b_min [3];
    logic signed [COORD_BITS-1:0] w_b_max [3];

    // Chain links: index 0 is the front end output, QB the last cell output
    aabb_pkg::t_sqrt_data w_link_data  [QB+1];
    logic                 w_link_valid [QB+1];

    logic                 w_en;
    logic [DB-1:0]        n_dist;
    logic                 n_touch;
    logic                 w_last_valid;
    logic                 r_skid_valid;
    logic [DB-1:0]        r_skid_dist;
    logic                 r_skid_touch;

    // Advance everything unless a stalled result sits in the skid
    assign w_en        = !r_skid_valid;
    assign i_box.ready = w_en;

    assign w_a_min = '{i_box.a_min_x, i_box.a_min_y, i_box.a_min_z};
    assign w_a_max = '{i_box.a_max_x, i_box.a_max_y, i_box.a_max_z};
    assign w_b_min = '{i_box.b_min_x, i_box.b_min_y, i_box.b_min_z};
    assign w_b_max = '{i_box.b_max_x, i_box.b_max_y, i_box.b_max_z};

    aabb_gap_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_box.valid),
        .i_a_min (w_a_min),
        .i_a_max (w_a_max),
        .i_b_min (w_b_min),
        .i_b_max (w_b_max),
        .o_valid (w_link_valid[0]),
        .o_data  (w_link_data[0])
    );

    // One cell per root bit, most significant first
    for (genvar c = 0; c < QB; c++) begin : g_cell
        aabb_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_link_valid[c]),
            .i_data  (w_link_data[c]),
            .o_valid (w_link_valid[c+1]),
            .o_data  (w_link_data[c+1])
        );
    end

    assign w_last_valid = w_link_valid[QB];

    // Saturate the 18-bit root into the result range; contact reads zero
    always_comb begin
        n_touch = w_link_data[QB].touch;
        if (w_link_data[QB].touch) begin
            n_dist = '0;
        end else if (w_link_data[QB].big || w_link_data[QB].root[QB-1]) begin
            n_dist = '1;
        end else begin
            n_dist = w_link_data[QB].root[DB-1:0];
        end
    end

    // Catch the chain output when the receiver stalls; release on ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            r_skid_valid <= w_last_valid && !o_dist.ready;
        end else if (o_dist.ready) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_dist  <= n_dist;
            r_skid_touch <= n_touch;
        end
    end

    assign o_dist.valid        = r_skid_valid || w_last_valid;
    assign o_dist.gap_distance = r_skid_valid ? r_skid_dist  : n_dist;
    assign o_dist.touching     = r_skid_valid ? r_skid_touch : n_touch;

endmodule

// ===== design/aabb_gap_front.sv =====
// ----------------------------------------------------------------------------
// aabb_gap_front: axis gaps, squares and their sum
// Three register stages: clamped gaps, squared gaps, sum of squares.
// ----------------------------------------------------------------------------
module aabb_gap_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_a_min [3],
    input  logic signed [COORD_BITS-1:0] i_a_max [3],
    input  logic signed [COORD_BITS-1:0] i_b_min [3],
    input  logic signed [COORD_BITS-1:0] i_b_max [3],
    output logic                         o_valid,
    output aabb_pkg::t_sqrt_data         o_data
);
    localparam int DB = aabb_pkg::DIST_BITS;
    localparam int GW = (COORD_BITS > DB) ? COORD_BITS : DB;

    logic [GW-1:0]                   w_gap_ext [3];
    logic [2:0]                      w_big;
    logic [2:0]                      w_zero;

    logic [DB-1:0]                   r_gap [3];
    logic                            r_big1;
    logic                            r_touch1;
    logic                            r_v1;
    logic [aabb_pkg::SQ_BITS-1:0]    r_sq [3];
    logic                            r_big2;
    logic                            r_touch2;
    logic                            r_v2;
    logic [aabb_pkg::SUM_BITS-1:0]   r_sum;
    logic                            r_big3;
    logic                            r_touch3;
    logic                            r_v3;
    logic [aabb_pkg::SUM_BITS-1:0]   n_sum;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [COORD_BITS:0] w_lo_diff;
        logic signed [COORD_BITS:0] w_hi_diff;
        logic [COORD_BITS-1:0]      w_gap;

        // Separation is positive and below 2^COORD_BITS, so the low bits hold it
        assign w_lo_diff = (COORD_BITS+1)'(i_b_min[k]) - (COORD_BITS+1)'(i_a_max[k]);
        assign w_hi_diff = (COORD_BITS+1)'(i_a_min[k]) - (COORD_BITS+1)'(i_b_max[k]);

        always_comb begin
            if (i_a_max[k] < i_b_min[k]) begin
                w_gap = w_lo_diff[COORD_BITS-1:0];
            end else if (i_a_min[k] > i_b_max[k]) begin
                w_gap = w_hi_diff[COORD_BITS-1:0];
            end else begin
                w_gap = '0;
            end
        end

        assign w_gap_ext[k] = GW'(w_gap);
        assign w_big[k]     = (w_gap_ext[k] >> DB) != '0;
        assign w_zero[k]    = (w_gap == '0);
    end

    assign n_sum = aabb_pkg::SUM_BITS'(r_sq[0]) + aabb_pkg::SUM_BITS'(r_sq[1])
                 + aabb_pkg::SUM_BITS'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_gap[k] <= w_gap_ext[k][DB-1:0];
                r_sq[k]  <= aabb_pkg::SQ_BITS'(r_gap[k]) * aabb_pkg::SQ_BITS'(r_gap[k]);
            end
            r_big1   <= |w_big;
            r_touch1 <= &w_zero;
            r_big2   <= r_big1;
            r_touch2 <= r_touch1;
            r_sum    <= n_sum;
            r_big3   <= r_big2;
            r_touch3 <= r_touch2;
        end
    end

    assign o_valid       = r_v3;
    assign o_data.rad    = r_sum;
    assign o_data.rem    = '0;
    assign o_data.root   = '0;
    assign o_data.big    = r_big3;
    assign o_data.touch  = r_touch3;

endmodule

// ===== design/aabb_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// aabb_sqrt_cell: one digit of the square root chain
// Take the next two radicand bits, try to set one root bit, pass on.
// ----------------------------------------------------------------------------
module aabb_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  aabb_pkg::t_sqrt_data i_data,
    output logic                 o_valid,
    output aabb_pkg::t_sqrt_data o_data
);
    localparam int RB = aabb_pkg::REM_BITS;
    localparam int QB = aabb_pkg::ROOT_BITS;
    localparam int SB = aabb_pkg::SUM_BITS;

    logic [RB-1:0]        w_rem_sh;
    logic [RB-1:0]        w_trial;
    logic                 w_ge;
    aabb_pkg::t_sqrt_data n_data;
    aabb_pkg::t_sqrt_data r_data;
    logic                 r_valid;

    // Remainder stays below 2^(RB-2) ahead of every step
    assign w_rem_sh = {i_data.rem[RB-3:0], i_data.rad[SB-1 -: 2]};
    assign w_trial  = {i_data.root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_comb begin
        n_data       = i_data;
        n_data.rad   = {i_data.rad[SB-3:0], 2'b00};
        n_data.rem   = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
        n_data.root  = {i_data.root[QB-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
